// ===== hw/rtl/spfs_pkg.sv =====
// ---------------------------------------------------------------------------
// SPI flash sequencer package
// Shared constants, command and result types, and the per-step decode that
// turns a queued command into one SPI byte, chip-select or reject action.
// ---------------------------------------------------------------------------
package spfs_pkg;

  // The page size must be a power of two.
  localparam int PAGE_BYTES = 256;
  localparam int OFS_W      = $clog2(PAGE_BYTES);
  localparam int ROOM_W     = $clog2(PAGE_BYTES + 1);
  localparam int ADDR_W     = 24;
  localparam int COUNT_W    = 25;
  localparam int QDEPTH     = 4;
  localparam int QPTR_W     = $clog2(QDEPTH);
  localparam int STEP_W     = 4;

  // Request kinds on the input channel.
  localparam logic [2:0] REQ_PROG   = 3'd0;
  localparam logic [2:0] REQ_DATA   = 3'd1;
  localparam logic [2:0] REQ_STATUS = 3'd2;
  localparam logic [2:0] REQ_SECTOR = 3'd3;
  localparam logic [2:0] REQ_CHIP   = 3'd4;

  // Result actions.
  localparam logic [1:0] ACT_SEND    = 2'd0;
  localparam logic [1:0] ACT_CS_HIGH = 2'd1;
  localparam logic [1:0] ACT_REJECT  = 2'd2;

  // Flash opcodes.
  localparam logic [7:0] OP_WREN  = 8'h06;
  localparam logic [7:0] OP_PP    = 8'h02;
  localparam logic [7:0] OP_RDSR  = 8'h05;
  localparam logic [7:0] OP_CE    = 8'hC7;
  localparam logic [7:0] OP_SE    = 8'h20;
  localparam logic [7:0] OP_DUMMY = 8'hFF;

  typedef enum logic [3:0] {
    K_REJECT,
    K_PAGE,
    K_DATA,
    K_DATA_END,
    K_BUSY,
    K_NEXT_PAGE,
    K_DONE,
    K_SECTOR,
    K_CHIP
  } kind_t;

  typedef struct packed {
    kind_t             kind;
    logic [ADDR_W-1:0] addr;
    logic [7:0]        b0;
    logic [7:0]        b1;
  } cmd_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] spi_byte;
    logic       poll;
    logic       done;
    logic       last;
  } res_t;

  // Even bits from ev, odd bits from od.
  function automatic logic [7:0] weave(input logic [3:0] ev, input logic [3:0] od);
    logic [7:0] w;
    for (int i = 0; i < 4; i++) begin
      w[2*i]   = ev[i];
      w[2*i+1] = od[i];
    end
    return w;
  endfunction

  function automatic res_t send_res(input logic [7:0] b, input logic poll, input logic last);
    res_t r;
    r.action   = ACT_SEND;
    r.spi_byte = b;
    r.poll     = poll;
    r.done     = 1'b0;
    r.last     = last;
    return r;
  endfunction

  function automatic res_t cs_res(input logic done, input logic last);
    res_t r;
    r.action   = ACT_CS_HIGH;
    r.spi_byte = 8'h00;
    r.poll     = 1'b0;
    r.done     = done;
    r.last     = last;
    return r;
  endfunction

  function automatic res_t reject_res();
    res_t r;
    r.action   = ACT_REJECT;
    r.spi_byte = 8'h00;
    r.poll     = 1'b0;
    r.done     = 1'b0;
    r.last     = 1'b1;
    return r;
  endfunction

  // Write enable, chip-select raise, page program opcode and the address.
  function automatic res_t page_step(input logic [ADDR_W-1:0] a, input logic [2:0] idx);
    res_t r;
    case (idx)
      3'd0: r = send_res(OP_WREN, 1'b0, 1'b0);
      3'd1: r = cs_res(1'b0, 1'b0);
      3'd2: r = send_res(OP_PP, 1'b0, 1'b0);
      3'd3: r = send_res(a[23:16], 1'b0, 1'b0);
      3'd4: r = send_res(a[15:8], 1'b0, 1'b0);
      3'd5: r = send_res(a[7:0], 1'b0, 1'b1);
      default: r = reject_res();
    endcase
    return r;
  endfunction

  function automatic res_t step_result(input cmd_t c, input logic [STEP_W-1:0] step);
    res_t             r;
    logic [STEP_W-1:0] prev;
    prev = step - STEP_W'(1);
    r = reject_res();
    case (c.kind)
      K_REJECT: r = reject_res();
      K_PAGE:   r = page_step(c.addr, step[2:0]);
      K_NEXT_PAGE: begin
        if (step == '0) begin
          r = cs_res(1'b0, 1'b0);
        end else begin
          r = page_step(c.addr, prev[2:0]);
        end
      end
      K_DATA, K_DATA_END: begin
        case (step)
          4'd0: r = send_res(weave(c.b0[7:4], c.b1[7:4]), 1'b0, 1'b0);
          4'd1: r = send_res(weave(c.b0[3:0], c.b1[3:0]), 1'b0, c.kind == K_DATA);
          4'd2: r = cs_res(1'b0, 1'b0);
          4'd3: r = send_res(OP_RDSR, 1'b0, 1'b0);
          default: r = send_res(OP_DUMMY, 1'b1, 1'b1);
        endcase
      end
      K_BUSY: r = send_res(OP_DUMMY, 1'b1, 1'b1);
      K_DONE: r = cs_res(1'b1, 1'b1);
      K_SECTOR: begin
        case (step)
          4'd0: r = send_res(OP_WREN, 1'b0, 1'b0);
          4'd1: r = cs_res(1'b0, 1'b0);
          4'd2: r = send_res(OP_SE, 1'b0, 1'b0);
          4'd3: r = send_res(c.addr[23:16], 1'b0, 1'b0);
          4'd4: r = send_res(c.addr[15:8], 1'b0, 1'b0);
          4'd5: r = send_res(c.addr[7:0], 1'b0, 1'b0);
          4'd6: r = cs_res(1'b0, 1'b0);
          4'd7: r = send_res(OP_RDSR, 1'b0, 1'b0);
          default: r = send_res(OP_DUMMY, 1'b1, 1'b1);
        endcase
      end
      K_CHIP: begin
        case (step)
          4'd0: r = send_res(OP_WREN, 1'b0, 1'b0);
          4'd1: r = cs_res(1'b0, 1'b0);
          4'd2: r = send_res(OP_CE, 1'b0, 1'b0);
          4'd3: r = cs_res(1'b0, 1'b0);
          4'd4: r = send_res(OP_RDSR, 1'b0, 1'b0);
          default: r = send_res(OP_DUMMY, 1'b1, 1'b1);
        endcase
      end
      default: r = reject_res();
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/spfs_front.sv =====
// ---------------------------------------------------------------------------
// SPI flash sequencer front end
// Accepts requests, checks them against the operation phase, updates address
// and count bookkeeping and queues one command per request but empty programs.
// ---------------------------------------------------------------------------
module spfs_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [2:0]                    in_req,
  input  logic [spfs_pkg::ADDR_W-1:0]   in_addr,
  input  logic [spfs_pkg::COUNT_W-1:0]  in_count,
  input  logic [7:0]                    in_b0,
  input  logic [7:0]                    in_b1,
  input  logic [7:0]                    in_status,
  output logic                          q_push,
  output spfs_pkg::cmd_t                q_cmd,
  input  logic                          q_full
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_DATA,
    PH_POLL
  } phase_t;

  phase_t                         phase, phase_next;
  logic                           op_is_program, op_is_program_next;
  logic [spfs_pkg::ADDR_W-1:0]    cur_address, cur_address_next;
  logic [spfs_pkg::COUNT_W-1:0]   bytes_left, bytes_left_next;
  logic [spfs_pkg::ROOM_W-1:0]    page_room, page_room_next;

  logic                           accept;
  logic [spfs_pkg::COUNT_W-1:0]   left_dec;
  logic [spfs_pkg::ROOM_W-1:0]    room_dec;
  logic [spfs_pkg::ROOM_W-1:0]    room_at_addr;
  logic [spfs_pkg::ROOM_W-1:0]    room_at_cur;
  logic                           do_push;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;
  assign q_push   = accept && do_push;

  assign left_dec = (bytes_left > spfs_pkg::COUNT_W'(2)) ?
                    bytes_left - spfs_pkg::COUNT_W'(2) : '0;
  assign room_dec = (page_room > spfs_pkg::ROOM_W'(2)) ?
                    page_room - spfs_pkg::ROOM_W'(2) : '0;

  assign room_at_addr = spfs_pkg::ROOM_W'(spfs_pkg::PAGE_BYTES) -
                        spfs_pkg::ROOM_W'(in_addr[spfs_pkg::OFS_W-1:0]);
  assign room_at_cur  = spfs_pkg::ROOM_W'(spfs_pkg::PAGE_BYTES) -
                        spfs_pkg::ROOM_W'(cur_address[spfs_pkg::OFS_W-1:0]);

  always_comb begin
    phase_next         = phase;
    op_is_program_next = op_is_program;
    cur_address_next   = cur_address;
    bytes_left_next    = bytes_left;
    page_room_next     = page_room;
    do_push            = 1'b1;
    q_cmd.kind         = spfs_pkg::K_REJECT;
    q_cmd.addr         = in_addr;
    q_cmd.b0           = in_b0;
    q_cmd.b1           = in_b1;

    if (in_req == spfs_pkg::REQ_PROG && phase == PH_IDLE) begin
      if (in_count == '0) begin
        do_push = 1'b0;
      end else begin
        q_cmd.kind         = spfs_pkg::K_PAGE;
        op_is_program_next = 1'b1;
        cur_address_next   = in_addr;
        bytes_left_next    = in_count;
        page_room_next     = room_at_addr;
        phase_next         = PH_DATA;
      end
    end else if (in_req == spfs_pkg::REQ_DATA && phase == PH_DATA) begin
      bytes_left_next  = left_dec;
      page_room_next   = room_dec;
      cur_address_next = cur_address + spfs_pkg::ADDR_W'(2);
      // A page ends when either the data or the room in the page runs out.
      if (left_dec == '0 || room_dec == '0) begin
        q_cmd.kind = spfs_pkg::K_DATA_END;
        phase_next = PH_POLL;
      end else begin
        q_cmd.kind = spfs_pkg::K_DATA;
      end
    end else if (in_req == spfs_pkg::REQ_STATUS && phase == PH_POLL) begin
      if (in_status[0]) begin
        q_cmd.kind = spfs_pkg::K_BUSY;
      end else if (op_is_program && bytes_left != '0) begin
        q_cmd.kind     = spfs_pkg::K_NEXT_PAGE;
        q_cmd.addr     = cur_address;
        page_room_next = room_at_cur;
        phase_next     = PH_DATA;
      end else begin
        q_cmd.kind = spfs_pkg::K_DONE;
        phase_next = PH_IDLE;
      end
    end else if (in_req == spfs_pkg::REQ_SECTOR && phase == PH_IDLE) begin
      q_cmd.kind         = spfs_pkg::K_SECTOR;
      op_is_program_next = 1'b0;
      phase_next         = PH_POLL;
    end else if (in_req == spfs_pkg::REQ_CHIP && phase == PH_IDLE) begin
      q_cmd.kind         = spfs_pkg::K_CHIP;
      op_is_program_next = 1'b0;
      phase_next         = PH_POLL;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      op_is_program <= 1'b0;
      cur_address   <= '0;
      bytes_left    <= '0;
      page_room     <= '0;
    end else if (accept) begin
      phase         <= phase_next;
      op_is_program <= op_is_program_next;
      cur_address   <= cur_address_next;
      bytes_left    <= bytes_left_next;
      page_room     <= page_room_next;
    end
  end

endmodule

// ===== hw/rtl/spfs_fifo.sv =====
// ---------------------------------------------------------------------------
// SPI flash sequencer command queue
// Small first-in first-out buffer of commands between the front end and the
// byte generator.
// ---------------------------------------------------------------------------
module spfs_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  spfs_pkg::cmd_t push_cmd,
  output logic           full,
  input  logic           pop,
  output spfs_pkg::cmd_t head,
  output logic           empty
);

  spfs_pkg::cmd_t                mem [spfs_pkg::QDEPTH];
  logic [spfs_pkg::QPTR_W-1:0]   wr_ptr;
  logic [spfs_pkg::QPTR_W-1:0]   rd_ptr;
  logic [spfs_pkg::QPTR_W:0]     count;
  logic                          do_push;
  logic                          do_pop;

  assign full    = (count == (spfs_pkg::QPTR_W + 1)'(spfs_pkg::QDEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + spfs_pkg::QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + spfs_pkg::QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (spfs_pkg::QPTR_W + 1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (spfs_pkg::QPTR_W + 1)'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/spfs_back.sv =====
// ---------------------------------------------------------------------------
// SPI flash sequencer byte generator
// Walks each queued command step by step and presents one result per cycle,
// while the output is not stalled, from a registered output stage.
// ---------------------------------------------------------------------------
module spfs_back (
  input  logic           clk,
  input  logic           rst,
  input  spfs_pkg::cmd_t head,
  input  logic           q_empty,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output spfs_pkg::res_t out_res
);

  logic [spfs_pkg::STEP_W-1:0] step;
  logic                        load;
  spfs_pkg::res_t              res;

  assign load  = !out_valid || out_ready;
  assign res   = spfs_pkg::step_result(head, step);
  assign q_pop = load && !q_empty && res.last;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      step      <= '0;
    end else if (load) begin
      out_valid <= !q_empty;
      if (!q_empty) begin
        step <= res.last ? '0 : step + spfs_pkg::STEP_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load && !q_empty) begin
      out_res <= res;
    end
  end

endmodule

// ===== hw/rtl/spi_flash_program_erase_sequencer.sv =====
// ---------------------------------------------------------------------------
// SPI flash program and erase sequencer
// Turns program, data, status and erase requests into single-SPI byte and
// chip-select actions for a NOR flash.
// ---------------------------------------------------------------------------
// A taken request is stored in the command queue; its first result is then registered at the output.
// Throughput: one result per cycle while m_tready is high; a request gives
// one result per step of its command (none for a zero-length program, up to
// nine), as the byte generator steps through the command.
// Requests are taken while the four-entry command queue has room.
// Reset (rst, synchronous, active high) returns to idle and empties the queue.
module spi_flash_program_erase_sequencer (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // start_address[23:0], byte_count[48:24], first_byte[56:49],
  // second_byte[64:57], flash_status[72:65], zero fill above
  input  logic [79:0] s_tdata,
  // req_type[2:0]
  input  logic [2:0]  s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // spi_byte[7:0], poll_status[8], op_done[9], zero fill above
  output logic [15:0] m_tdata,
  // action[1:0]
  output logic [1:0]  m_tuser,
  output logic        m_tlast
);

  spfs_pkg::cmd_t push_cmd;
  spfs_pkg::cmd_t head;
  spfs_pkg::res_t out_res;
  logic           push;
  logic           full;
  logic           pop;
  logic           empty;

  spfs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_req    (s_tuser),
    .in_addr   (s_tdata[23:0]),
    .in_count  (s_tdata[48:24]),
    .in_b0     (s_tdata[56:49]),
    .in_b1     (s_tdata[64:57]),
    .in_status (s_tdata[72:65]),
    .q_push    (push),
    .q_cmd     (push_cmd),
    .q_full    (full)
  );

  spfs_fifo u_fifo (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (full),
    .pop      (pop),
    .head     (head),
    .empty    (empty)
  );

  spfs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .head      (head),
    .q_empty   (empty),
    .q_pop     (pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_res   (out_res)
  );

  assign m_tdata = {6'b0, out_res.done, out_res.poll, out_res.spi_byte};
  assign m_tuser = out_res.action;
  assign m_tlast = out_res.last;

`ifndef SYNTHESIS
  // A rejection is always the only result of its request.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser == spfs_pkg::ACT_REJECT |-> m_tlast)
    else $error("reject result not marked last");

  // Completion is signaled only on the final chip-select raise.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[9] |-> m_tlast && m_tuser == spfs_pkg::ACT_CS_HIGH)
    else $error("op_done on a result that is not a final chip-select raise");

  // Status polls always clock out the dummy byte.
  assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[8] |-> m_tdata[7:0] == spfs_pkg::OP_DUMMY && m_tlast)
    else $error("status poll without dummy byte");
`endif

endmodule
